@@ hw/rtl/rgb_backlight_controller_core_macros.svh @@
// Assertion macros for the RGB backlight controller core.
// Taken in by the top level; relies on signals named clock and reset there.
`ifndef RGB_BACKLIGHT_CONTROLLER_CORE_MACROS_SVH
`define RGB_BACKLIGHT_CONTROLLER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its trigger.
`define RGBBL_ASSERT_NOW(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its trigger.
`define RGBBL_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rgbbl_pkg.sv @@
// Shared types, codes and helper functions of the RGB backlight controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rgbbl_pkg;

   localparam int unsigned PctW   = 7;
   localparam int unsigned ProdW  = 2 * PctW;
   localparam logic [6:0]  PctMax = 7'd100;

   // Reciprocal of 100 scaled by 2^22; exact floor for products up to 100*100
   localparam logic [15:0] RecipHundred = 16'd41944;
   localparam int unsigned RecipShift   = 22;
   localparam int unsigned ScaledW      = ProdW + 16;

   localparam logic [1:0] LevelHigh    = 2'd3;
   localparam logic [2:0] ColourWhite  = 3'd5;
   localparam logic [2:0] ColourLast   = 3'd6;
   localparam logic [7:0] LevelCount   = 8'd4;
   localparam logic [7:0] ColourCount  = 8'd7;

   // ASCII channel selectors
   localparam logic [7:0] LetterRedLo   = 8'h72;
   localparam logic [7:0] LetterRedUp   = 8'h52;
   localparam logic [7:0] LetterGreenLo = 8'h67;
   localparam logic [7:0] LetterGreenUp = 8'h47;
   localparam logic [7:0] LetterBlueLo  = 8'h62;
   localparam logic [7:0] LetterBlueUp  = 8'h42;

   // Configuration register indexes
   localparam logic [1:0] CsrLevelLow    = 2'd0;
   localparam logic [1:0] CsrLevelMedium = 2'd1;
   localparam logic [1:0] CsrLevelHigh   = 2'd2;

   typedef enum logic [3:0] {
      OP_ENABLE      = 4'd0,
      OP_DISABLE     = 4'd1,
      OP_TOGGLE      = 4'd2,
      OP_SET_BRIGHT  = 4'd3,
      OP_INCREASE    = 4'd4,
      OP_DECREASE    = 4'd5,
      OP_SET_LEVEL   = 4'd6,
      OP_LEVEL_STEP  = 4'd7,
      OP_SET_RGB     = 4'd8,
      OP_SET_CHANNEL = 4'd9,
      OP_SET_COLOUR  = 4'd10,
      OP_COLOUR_STEP = 4'd11,
      OP_RESTORE     = 4'd12,
      OP_QUERY       = 4'd13
   } op_type;

   typedef struct packed {
      logic [3:0] operation;
      logic [7:0] amount;
      logic [7:0] channel_letter;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       enable_in;
   } req_type;

   typedef struct packed {
      logic [6:0] drive_red;
      logic [6:0] drive_green;
      logic [6:0] drive_blue;
      logic       is_on;
      logic [6:0] brightness_now;
      logic [6:0] colour_red;
      logic [6:0] colour_green;
      logic [6:0] colour_blue;
   } rsp_type;

   // Settings after a command, with the unscaled channel products
   typedef struct packed {
      logic             on;
      logic [6:0]       brightness;
      logic [6:0]       red;
      logic [6:0]       green;
      logic [6:0]       blue;
      logic [ProdW-1:0] prod_red;
      logic [ProdW-1:0] prod_green;
      logic [ProdW-1:0] prod_blue;
   } mid_type;

   typedef struct packed {
      logic [6:0] low;
      logic [6:0] middle;
      logic [6:0] high;
   } levels_type;

   // Clamp an 8-bit value to 0..100
   function automatic logic [6:0] sat_pct(input logic [7:0] v);
      return (v > {1'b0, PctMax}) ? PctMax : v[6:0];
   endfunction

   // Brightness of a preset level; level zero is off
   function automatic logic [6:0] level_pct(input logic [1:0] idx, input levels_type lv);
      logic [6:0] pct;
      unique case (idx)
         2'd1:    pct = sat_pct({1'b0, lv.low});
         2'd2:    pct = sat_pct({1'b0, lv.middle});
         2'd3:    pct = sat_pct({1'b0, lv.high});
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

   // Preset colours: red, yellow, cyan, blue, green, white, magenta
   function automatic logic [20:0] palette(input logic [2:0] idx);
      logic [20:0] rgb;
      unique case (idx)
         3'd0:    rgb = {PctMax, 7'd0,   7'd0};
         3'd1:    rgb = {PctMax, PctMax, 7'd0};
         3'd2:    rgb = {7'd0,   PctMax, PctMax};
         3'd3:    rgb = {7'd0,   7'd0,   PctMax};
         3'd4:    rgb = {7'd0,   PctMax, 7'd0};
         3'd5:    rgb = {PctMax, PctMax, PctMax};
         3'd6:    rgb = {PctMax, 7'd0,   PctMax};
         default: rgb = {PctMax, PctMax, PctMax};
      endcase
      return rgb;
   endfunction

endpackage

@@ hw/rtl/rgbbl_cmd.sv @@
// Command decoder and settings registers of the RGB backlight controller.
// Holds the level configuration; depends on rgbbl_pkg.
`timescale 1ns / 1ps

module rgbbl_cmd #(
   parameter bit DEFAULT_ON         = 1'b1,
   parameter int DEFAULT_BRIGHTNESS = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_wr_data,
   input  rgbbl_pkg::req_type cmd,
   input  logic              cmd_go,
   output rgbbl_pkg::mid_type settings
);

   rgbbl_pkg::levels_type levels_ff;
   logic       on_ff,     on_in;
   logic [6:0] bright_ff, bright_in;
   logic [6:0] red_ff,    red_in;
   logic [6:0] green_ff,  green_in;
   logic [6:0] blue_ff,   blue_in;
   logic [1:0] lvl_ff,    lvl_in;
   logic [2:0] col_ff,    col_in;

   logic [8:0]  inc_sum;
   logic [1:0]  lvl_step;
   logic [2:0]  col_step;
   logic [6:0]  amt_sat;
   logic [20:0] pal_amt;
   logic [20:0] pal_step;

   assign inc_sum  = {2'b0, bright_ff} + {1'b0, cmd.amount};
   assign lvl_step = lvl_ff + 2'd1;
   assign col_step = (col_ff == rgbbl_pkg::ColourLast) ? 3'd0 : col_ff + 3'd1;
   assign amt_sat  = rgbbl_pkg::sat_pct(cmd.amount);
   assign pal_amt  = rgbbl_pkg::palette(cmd.amount[2:0]);
   assign pal_step = rgbbl_pkg::palette(col_step);

   // Decode one command into the next settings
   always_comb begin
      on_in     = on_ff;
      bright_in = bright_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      lvl_in    = lvl_ff;
      col_in    = col_ff;
      unique case (rgbbl_pkg::op_type'(cmd.operation))
         rgbbl_pkg::OP_ENABLE:     on_in = 1'b1;
         rgbbl_pkg::OP_DISABLE:    on_in = 1'b0;
         rgbbl_pkg::OP_TOGGLE:     on_in = !on_ff;
         rgbbl_pkg::OP_SET_BRIGHT: bright_in = amt_sat;
         rgbbl_pkg::OP_INCREASE: begin
            bright_in = (inc_sum > 9'(rgbbl_pkg::PctMax)) ? rgbbl_pkg::PctMax
                                                          : inc_sum[6:0];
            on_in     = 1'b1;
         end
         rgbbl_pkg::OP_DECREASE: begin
            bright_in = ({1'b0, bright_ff} <= cmd.amount) ? 7'd0
                                                          : bright_ff - cmd.amount[6:0];
         end
         rgbbl_pkg::OP_SET_LEVEL: begin
            if (cmd.amount < rgbbl_pkg::LevelCount) begin
               lvl_in    = cmd.amount[1:0];
               bright_in = rgbbl_pkg::level_pct(cmd.amount[1:0], levels_ff);
               on_in     = (cmd.amount[1:0] != 2'd0);
            end
         end
         rgbbl_pkg::OP_LEVEL_STEP: begin
            lvl_in    = lvl_step;
            bright_in = rgbbl_pkg::level_pct(lvl_step, levels_ff);
            on_in     = (lvl_step != 2'd0);
         end
         rgbbl_pkg::OP_SET_RGB: begin
            red_in   = rgbbl_pkg::sat_pct(cmd.red_in);
            green_in = rgbbl_pkg::sat_pct(cmd.green_in);
            blue_in  = rgbbl_pkg::sat_pct(cmd.blue_in);
         end
         rgbbl_pkg::OP_SET_CHANNEL: begin
            priority if (cmd.channel_letter == rgbbl_pkg::LetterRedLo ||
                         cmd.channel_letter == rgbbl_pkg::LetterRedUp) begin
               red_in = amt_sat;
            end else if (cmd.channel_letter == rgbbl_pkg::LetterGreenLo ||
                         cmd.channel_letter == rgbbl_pkg::LetterGreenUp) begin
               green_in = amt_sat;
            end else if (cmd.channel_letter == rgbbl_pkg::LetterBlueLo ||
                         cmd.channel_letter == rgbbl_pkg::LetterBlueUp) begin
               blue_in = amt_sat;
            end else begin
               red_in = red_ff;
            end
         end
         rgbbl_pkg::OP_SET_COLOUR: begin
            if (cmd.amount < rgbbl_pkg::ColourCount) begin
               col_in                      = cmd.amount[2:0];
               {red_in, green_in, blue_in} = pal_amt;
            end
         end
         rgbbl_pkg::OP_COLOUR_STEP: begin
            col_in                      = col_step;
            {red_in, green_in, blue_in} = pal_step;
         end
         rgbbl_pkg::OP_RESTORE: begin
            on_in     = cmd.enable_in;
            bright_in = amt_sat;
            red_in    = rgbbl_pkg::sat_pct(cmd.red_in);
            green_in  = rgbbl_pkg::sat_pct(cmd.green_in);
            blue_in   = rgbbl_pkg::sat_pct(cmd.blue_in);
         end
         default: on_in = on_ff;
      endcase
   end

   // Settings registers: advance when a command leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff     <= DEFAULT_ON;
         bright_ff <= 7'(DEFAULT_BRIGHTNESS);
         red_ff    <= rgbbl_pkg::PctMax;
         green_ff  <= rgbbl_pkg::PctMax;
         blue_ff   <= rgbbl_pkg::PctMax;
         lvl_ff    <= rgbbl_pkg::LevelHigh;
         col_ff    <= rgbbl_pkg::ColourWhite;
      end else if (cmd_go) begin
         on_ff     <= on_in;
         bright_ff <= bright_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         lvl_ff    <= lvl_in;
         col_ff    <= col_in;
      end
   end

   // Level configuration registers; other indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff.low    <= 7'd30;
         levels_ff.middle <= 7'd60;
         levels_ff.high   <= 7'd100;
      end else if (csr_wr_en) begin
         if (csr_index == rgbbl_pkg::CsrLevelLow) begin
            levels_ff.low <= csr_wr_data;
         end
         if (csr_index == rgbbl_pkg::CsrLevelMedium) begin
            levels_ff.middle <= csr_wr_data;
         end
         if (csr_index == rgbbl_pkg::CsrLevelHigh) begin
            levels_ff.high <= csr_wr_data;
         end
      end
   end

   // Hand the new settings on with colour times brightness
   always_comb begin
      settings.on         = on_in;
      settings.brightness = bright_in;
      settings.red        = red_in;
      settings.green      = green_in;
      settings.blue       = blue_in;
      settings.prod_red   = {7'd0, red_in}   * {7'd0, bright_in};
      settings.prod_green = {7'd0, green_in} * {7'd0, bright_in};
      settings.prod_blue  = {7'd0, blue_in}  * {7'd0, bright_in};
   end

endmodule

@@ hw/rtl/rgbbl_scale.sv @@
// Drive scaling of the RGB backlight controller: product over 100, gated by on.
// Depends on rgbbl_pkg.
`timescale 1ns / 1ps

module rgbbl_scale (
   input  rgbbl_pkg::mid_type settings,
   output rgbbl_pkg::rsp_type result
);

   logic [rgbbl_pkg::ScaledW-1:0] sc_red;
   logic [rgbbl_pkg::ScaledW-1:0] sc_green;
   logic [rgbbl_pkg::ScaledW-1:0] sc_blue;

   // Divide by 100 through the scaled reciprocal
   assign sc_red   = {16'd0, settings.prod_red}   * {14'd0, rgbbl_pkg::RecipHundred};
   assign sc_green = {16'd0, settings.prod_green} * {14'd0, rgbbl_pkg::RecipHundred};
   assign sc_blue  = {16'd0, settings.prod_blue}  * {14'd0, rgbbl_pkg::RecipHundred};

   always_comb begin
      result.drive_red      = settings.on ? sc_red[rgbbl_pkg::RecipShift +: 7]   : 7'd0;
      result.drive_green    = settings.on ? sc_green[rgbbl_pkg::RecipShift +: 7] : 7'd0;
      result.drive_blue     = settings.on ? sc_blue[rgbbl_pkg::RecipShift +: 7]  : 7'd0;
      result.is_on          = settings.on;
      result.brightness_now = settings.brightness;
      result.colour_red     = settings.red;
      result.colour_green   = settings.green;
      result.colour_blue    = settings.blue;
   end

endmodule

@@ hw/rtl/rgb_backlight_controller_core.sv @@
// Top level of the RGB backlight controller: handshake stages around decoder and scaler.
// Depends on rgbbl_pkg, rgbbl_cmd, rgbbl_scale and the assertion macro header.
`timescale 1ns / 1ps
`include "rgb_backlight_controller_core_macros.svh"

// Every accepted command item gives exactly one result item, in order. The block
// takes one item per clock while the result side is not stalled; an item passes
// from the input register through the settings stage to the result register,
// where it is presented. The settings are updated as an item leaves the input
// register, so each item sees all earlier ones; the divide by 100 of the drive
// values runs in the following stage. Each stage holds its item only while the
// stage after it is full and stalled. The user must see that level registers are
// written through the csr_ port only while no item is in flight; the block does not
// enforce it. Out-of-range register values are clamped to 100 where they are used.

module rgb_backlight_controller_core #(
   parameter bit DEFAULT_ON         = 1'b1,
   parameter int DEFAULT_BRIGHTNESS = 100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rgbbl_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rgbbl_pkg::rsp_type rsp_payload,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_wr_data
);

   logic               in_v_ff;
   rgbbl_pkg::req_type in_d_ff;
   logic               mid_v_ff;
   rgbbl_pkg::mid_type mid_d_ff;
   logic               out_v_ff;
   rgbbl_pkg::rsp_type out_d_ff;

   logic               rdy_in, rdy_mid, rdy_out;
   logic               cmd_go, mid_go;
   rgbbl_pkg::mid_type settings;
   rgbbl_pkg::rsp_type scaled;

   logic               drive_in_colour;
   logic               drive_dark;
   logic               pct_in_range;

   // Stage readiness: a stage can take an item when empty or when it drains
   assign rdy_out   = !out_v_ff || !rsp_stall;
   assign rdy_mid   = !mid_v_ff || rdy_out;
   assign rdy_in    = !in_v_ff  || rdy_mid;
   assign req_stall = !rdy_in;
   assign cmd_go    = in_v_ff  && rdy_mid;
   assign mid_go    = mid_v_ff && rdy_out;

   rgbbl_cmd #(
      .DEFAULT_ON         (DEFAULT_ON),
      .DEFAULT_BRIGHTNESS (DEFAULT_BRIGHTNESS)
   ) u_cmd (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (in_d_ff),
      .cmd_go      (cmd_go),
      .settings    (settings)
   );

   rgbbl_scale u_scale (
      .settings (mid_d_ff),
      .result   (scaled)
   );

   // Valid bits of the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         mid_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy_in) begin
            in_v_ff <= req_valid;
         end
         if (rdy_mid) begin
            mid_v_ff <= in_v_ff;
         end
         if (rdy_out) begin
            out_v_ff <= mid_v_ff;
         end
      end
   end

   // Payload registers: load when the stage advances
   always_ff @(posedge clock) begin
      if (rdy_in && req_valid) begin
         in_d_ff <= req_payload;
      end
      if (cmd_go) begin
         mid_d_ff <= settings;
      end
      if (mid_go) begin
         out_d_ff <= scaled;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_d_ff;

   // Result properties checked below
   assign drive_in_colour = (rsp_payload.drive_red   <= rsp_payload.colour_red) &&
                            (rsp_payload.drive_green <= rsp_payload.colour_green) &&
                            (rsp_payload.drive_blue  <= rsp_payload.colour_blue);
   assign drive_dark      = (rsp_payload.drive_red == 7'd0) &&
                            (rsp_payload.drive_green == 7'd0) &&
                            (rsp_payload.drive_blue == 7'd0);
   assign pct_in_range    = (rsp_payload.brightness_now <= rgbbl_pkg::PctMax) &&
                            (rsp_payload.colour_red <= rgbbl_pkg::PctMax) &&
                            (rsp_payload.colour_green <= rgbbl_pkg::PctMax) &&
                            (rsp_payload.colour_blue <= rgbbl_pkg::PctMax);

   // Drive never exceeds the stored colour
   `RGBBL_ASSERT_NOW(a_drive_bound, rsp_valid, drive_in_colour, "drive above colour")
   // An off block drives nothing
   `RGBBL_ASSERT_NOW(a_off_dark, rsp_valid && !rsp_payload.is_on, drive_dark, "drive while off")
   // Stored settings stay within percent range
   `RGBBL_ASSERT_NOW(a_pct_range, rsp_valid, pct_in_range, "setting above 100")
   // A held input item keeps the next stage occupied
   `RGBBL_ASSERT_NEXT(a_hold_full, in_v_ff && !rdy_mid, in_v_ff && mid_v_ff, "lost item in pipeline")

endmodule
